>>> sv/swm_pkg.sv
// Package for the sliding window median block.
// Holds sizes, controller state type and controller/datapath command and status structs.
package swm_pkg;
	localparam int WINDOW_MAX = 64;
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int KW = $clog2(WINDOW_MAX + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CREAD,
		ST_CLOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_RANK,
		ST_FINISH
	} swm_state_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic cread;
		logic cload;
		logic scan;
		logic rank;
		logic finish;
	} swm_cmd_t;

	typedef struct packed {
		logic full;
		logic last_i;
		logic last_j;
		logic out_free;
	} swm_status_t;
endpackage

>>> sv/swm_ctrl.sv
// Controller state machine for the sliding window median block.
// Depends on swm_pkg; drives swm_datapath through swm_cmd_t.
module swm_ctrl import swm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  swm_status_t status,
	output swm_cmd_t    cmd
);
	swm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CHECK;
			ST_CHECK:  state_d = status.full ? ST_CREAD : ST_IDLE;
			ST_CREAD:  state_d = ST_CLOAD;
			ST_CLOAD:  state_d = ST_SCAN;
			ST_SCAN:   if (status.last_j) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_RANK;
			ST_RANK:   state_d = status.last_i ? ST_FINISH : ST_CREAD;
			ST_FINISH: if (status.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			ST_CHECK:  cmd.init = 1'b1;
			ST_CREAD:  cmd.cread = 1'b1;
			ST_CLOAD:  cmd.cload = 1'b1;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_RANK:   cmd.rank = 1'b1;
			ST_FINISH: cmd.finish = status.out_free;
			default:   cmd = '0;
		endcase
	end
endmodule

>>> sv/swm_datapath.sv
// Datapath for the sliding window median block: sample ring, rank counters, output register.
// Depends on swm_pkg; commanded by swm_ctrl.
module swm_datapath import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  swm_cmd_t           cmd,
	output swm_status_t        status,
	input  logic signed [31:0] sample,
	input  logic               start_req,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	output logic signed [32:0] median_doubled,
	output logic               out_valid,
	input  logic               out_ready
);
	logic signed [31:0] mem [WINDOW_MAX];
	logic signed [31:0] rdata_q, cand_q, lo_q, hi_q;
	logic [AW-1:0] wp_q, wbase, raddr;
	logic [KW-1:0] fill_q, i_q, j_q, less_q, leq_q, ksz_q, k, rhi, rlo;
	logic cmp_valid_q, out_valid_q;
	logic signed [32:0] out_q;

	always_comb begin
		if (ksz_q == '0) k = KW'(1);
		else if (ksz_q > KW'(WINDOW_MAX)) k = KW'(WINDOW_MAX);
		else k = ksz_q;
	end
	assign rhi = k >> 1;
	assign rlo = rhi - KW'(1);
	assign wbase = start_req ? '0 : wp_q;
	assign raddr = wp_q - AW'(1) - (cmd.cread ? i_q[AW-1:0] : j_q[AW-1:0]);

	assign status.full = fill_q >= k;
	assign status.last_i = i_q == k - KW'(1);
	assign status.last_j = j_q == k - KW'(1);
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.accept) mem[wbase] <= sample;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			fill_q <= '0;
			ksz_q <= KW'(1);
			i_q <= '0;
			j_q <= '0;
			less_q <= '0;
			leq_q <= '0;
			cmp_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) ksz_q <= cfg_wdata;
			if (cmd.accept) begin
				wp_q <= wbase + AW'(1);
				if (start_req) fill_q <= KW'(1);
				else if (fill_q < KW'(WINDOW_MAX)) fill_q <= fill_q + KW'(1);
			end
			if (cmd.init) i_q <= '0;
			if (cmd.rank) i_q <= i_q + KW'(1);
			if (cmd.cload) begin
				j_q <= '0;
				less_q <= '0;
				leq_q <= '0;
			end
			if (cmd.scan) j_q <= j_q + KW'(1);
			cmp_valid_q <= cmd.scan;
			if (cmp_valid_q) begin
				if (rdata_q < cand_q) less_q <= less_q + KW'(1);
				if (rdata_q <= cand_q) leq_q <= leq_q + KW'(1);
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cload) cand_q <= rdata_q;
		if (cmd.rank) begin
			if (less_q <= rhi && rhi < leq_q) begin
				hi_q <= cand_q;
				if (k[0]) lo_q <= cand_q;
			end
			if (!k[0] && less_q <= rlo && rlo < leq_q) lo_q <= cand_q;
		end
		if (cmd.finish) out_q <= 33'(hi_q) + 33'(lo_q);
	end

	assign median_doubled = out_q;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KW'(WINDOW_MAX)) else $error("fill count overflow");
	a_less_leq: assert property (@(posedge clk) disable iff (!arst_n)
		less_q <= leq_q) else $error("rank counts inconsistent");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q) else $error("result not presented");
	a_scan_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> cmp_valid_q) else $error("compare stage lost");
`endif
endmodule

>>> sv/sliding_window_median.sv
// Sliding window median filter, top level.
// Channels: input item (sample, start_req) on in_valid/in_ready; result
// (median_doubled, twice the median of the last window_size samples) on
// out_valid/out_ready; window_size written on cfg_valid/cfg_ready, always ready.
// An item is accepted only while the controller is idle. Start_req empties
// the window before the sample enters. No result is given until the window
// holds window_size samples (0 acts as 1, above 64 acts as 64).
// With window k, an item that gives no result ends at the fill check;
// else the rank scan reads the single sample ring read port once per
// compare, k compares for each of k candidates.
// The result waits in an output register; a new item is accepted while it
// waits, and the next result holds until the receiver takes the old one.
// Reset clears pointers, fill count and sets window_size to 1; the ring
// holds stale data that the fill count keeps from being read.
module sliding_window_median import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample,
	input  logic               start_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [32:0] median_doubled,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [6:0]         window_size
);
	swm_cmd_t cmd;
	swm_status_t status;

	assign cfg_ready = 1'b1;

	swm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.status(status), .cmd(cmd)
	);

	swm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.sample(sample), .start_req(start_req),
		.cfg_we(cfg_valid && cfg_ready), .cfg_wdata(window_size),
		.median_doubled(median_doubled), .out_valid(out_valid), .out_ready(out_ready)
	);
endmodule

>>> tb/sv/swm_checker.sv
// Checker for the sliding window median block: watches the config, input and result channels.
// Keeps its own sample ring and window size, predicts 2x median per full window, compares in order.
// Depends on swm_pkg for WINDOW_MAX.
module swm_checker import swm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] sample,
	input  logic               start_req,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [32:0] median_doubled,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [6:0]         window_size,
	output int                 fail_count,
	output int                 pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] history [WINDOW_MAX];
	int                 head_slot;
	int                 filled;
	logic [6:0]         win_reg;
	logic signed [32:0] median_queue [$];

	task automatic report(input string what, input logic signed [32:0] got,
			input logic signed [32:0] want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic take_sample(input logic signed [31:0] s, input logic restart);
		int                 k;
		int                 idx;
		int                 p;
		logic signed [31:0] ordered [WINDOW_MAX];
		logic signed [31:0] v;
		logic signed [32:0] m;
		if (restart) begin
			head_slot = 0;
			filled = 0;
		end
		history[head_slot] = s;
		head_slot = (head_slot + 1) % WINDOW_MAX;
		if (filled < WINDOW_MAX)
			filled++;
		k = (win_reg == 0) ? 1 : (win_reg > WINDOW_MAX ? WINDOW_MAX : int'(win_reg));
		if (filled < k)
			return;
		for (int j = 0; j < k; j++) begin
			idx = (head_slot + WINDOW_MAX - 1 - j) % WINDOW_MAX;
			v = history[idx];
			p = j;
			while (p > 0 && ordered[p-1] > v) begin
				ordered[p] = ordered[p-1];
				p--;
			end
			ordered[p] = v;
		end
		if (k % 2)
			m = 33'(ordered[k/2]) + 33'(ordered[k/2]);
		else
			m = 33'(ordered[k/2-1]) + 33'(ordered[k/2]);
		median_queue.insert(median_queue.size(), m);
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
		head_slot = 0;
		filled = 0;
		win_reg = 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot = 0;
			filled = 0;
			win_reg = 1;
			median_queue.delete();
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (median_queue.size() == 0)
					report("unexpected item", median_doubled, '0);
				else if (median_doubled !== median_queue[0]) begin
					report("median_doubled", median_doubled, median_queue[0]);
					void'(median_queue.pop_front());
				end else
					void'(median_queue.pop_front());
			end
			if (cfg_valid && cfg_ready)
				win_reg = window_size;
			if (in_valid && in_ready)
				take_sample(sample, start_req);
			pending_count = median_queue.size();
		end
	end
endmodule

>>> tb/sv/tb_top.sv
// Top of the sliding window median testbench: clock, reset, stimulus and verdict.
// Drives samples, window sizes and result stalls; swm_checker does the prediction and comparison.
// Depends on sliding_window_median and swm_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] sample = '0;
	logic               start_req = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [32:0] median_doubled;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [6:0]         window_size = 7'd1;
	int                 fail_count;
	int                 pending_count;
	int                 idle_cycles = 0;
	logic               stall_on = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sliding_window_median DUT (.*);

	swm_checker checker_i (.*);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom();
		endcase
	endfunction

	task automatic idle(input int n);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_sample(input logic signed [31:0] s, input logic restart);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			idle(g);
		end
		in_valid <= 1'b1;
		sample <= s;
		start_req <= restart;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic set_window(input logic [6:0] w);
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		idle(64 * 68 + 10);
		cfg_valid <= 1'b1;
		window_size <= w;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (!stall_on)
			out_ready <= 1'b1;
		else if ($urandom_range(0, 9) == 0)
			out_ready <= 1'b0;
		else if ($urandom_range(0, 2) == 0)
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sliding_window_median regression: fail");
			$finish;
		end
	end

	initial begin
		logic [6:0] w;
		int         n;
		idle(5);
		arst_n <= 1'b1;
		idle(2);
		// directed: extremes with window 1, restart, even and odd sizes
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh00000000, 1'b1);
		send_sample(-32'sd1, 1'b0);
		set_window(7'd2);
		send_sample(32'sh7fffffff, 1'b1);
		send_sample(32'sh7fffffff, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		set_window(7'd0);
		send_sample(32'sd5, 1'b1);
		send_sample(-32'sd3, 1'b0);
		set_window(7'd3);
		send_sample(32'sd9, 1'b1);
		send_sample(32'sd1, 1'b0);
		send_sample(32'sd4, 1'b0);
		send_sample(32'sh80000000, 1'b0);
		set_window(7'd127);
		for (int i = 0; i < 66; i++)
			send_sample(pick_sample(), i == 0);
		set_window(7'd64);
		send_sample(pick_sample(), 1'b0);
		// random phases; mostly small windows to keep run time down
		n = 0;
		while (n < 1500) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(0, 1) ? 7'd64 : 7'd127;
				1: w = 7'($urandom_range(65, 126));
				2: w = 7'd0;
				default: w = 7'($urandom_range(1, 9));
			endcase
			stall_on = $urandom_range(0, 3) != 0;
			set_window(w);
			repeat ((w > 9) ? 70 : $urandom_range(5, 60)) begin
				send_sample(pick_sample(), $urandom_range(0, 19) == 0);
				n++;
			end
		end
		in_valid <= 1'b0;
		stall_on = 1'b1;
		while (pending_count != 0)
			@(posedge clk);
		idle(64 * 68 + 10);
		if (fail_count == 0)
			$display("sliding_window_median regression: pass");
		else
			$display("sliding_window_median regression: fail");
		$finish;
	end
endmodule
